/* rtl/asq_pkg.sv */
package asq_pkg;

    localparam int unsigned READING_W = 10;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CONFIRM_W = 16;
    localparam int unsigned SPEED_W   = 8;
    localparam int unsigned GAIN_W    = 8;
    localparam int unsigned CORR_W    = 19;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 40;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_MARGIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_HYSTERESIS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TIME       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH_GAIN          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SPEED        = 3'd6;

    // Register values after reset.
    localparam logic [READING_W-1:0] RST_DISTANCE_THRESHOLD = 10'd300;
    localparam logic [READING_W-1:0] RST_TURN_MARGIN        = 10'd100;
    localparam logic [READING_W-1:0] RST_TURN_HYSTERESIS    = 10'd30;
    localparam logic [CONFIRM_W-1:0] RST_CONFIRM_TIME       = 16'd50;
    localparam logic [GAIN_W-1:0]    RST_PUSH_GAIN          = 8'd1;
    localparam logic [SPEED_W-1:0]   RST_CRUISE_SPEED       = 8'd200;
    localparam logic [SPEED_W-1:0]   RST_INNER_SPEED        = 8'd100;

    typedef enum logic [1:0] {
        DIR_STRAIGHT = 2'd0,
        DIR_LEFT     = 2'd1,
        DIR_RIGHT    = 2'd2
    } t_steer;

    typedef struct packed {
        logic [READING_W-1:0] distance_threshold;
        logic [READING_W-1:0] turn_margin;
        logic [READING_W-1:0] turn_hysteresis;
        logic [CONFIRM_W-1:0] confirm_time;
        logic [GAIN_W-1:0]    push_gain;
        logic [SPEED_W-1:0]   cruise_speed;
        logic [SPEED_W-1:0]   inner_speed;
    } t_cfg;

    // Packed so that the last field sits in the lowest bits.
    typedef struct packed {
        logic [TIME_W-1:0]    now_ms;
        logic [READING_W-1:0] right_reading;
        logic [READING_W-1:0] left_reading;
        logic [READING_W-1:0] front_right_reading;
        logic [READING_W-1:0] front_left_reading;
    } t_in_item;

    typedef struct packed {
        logic                     push_mode;
        t_steer                   steering_now;
        logic [SPEED_W-1:0]       right_speed;
        logic [SPEED_W-1:0]       left_speed;
        logic signed [CORR_W-1:0] push_correction;
    } t_result;

    typedef struct packed {
        t_steer            active_steering;
        t_steer            candidate_steering;
        logic [TIME_W-1:0] candidate_start_time;
        logic              candidate_valid;
    } t_steer_state;

    localparam t_steer_state STATE_RESET = '{
        active_steering:      DIR_STRAIGHT,
        candidate_steering:   DIR_STRAIGHT,
        candidate_start_time: '0,
        candidate_valid:      1'b0
    };

endpackage

/* rtl/approach_steering_qualifier.sv */
// Approach steering qualifier.
// Input stream (i_s_axis_*): one item per sensor sample set, holding the four
// distance readings and the millisecond timestamp. Output stream (o_m_axis_*):
// one result item per input item, in order; tuser carries push mode, tdata the
// correction, both wheel speeds and the steering after this item.
// Configuration (i_cfg_*): a register is written when i_cfg_valid is high;
// o_cfg_ready is always high. Write only while no item is in flight.
// An accepted item enters the input register; its result is formed from it
// and moves into the output register when that register is free or being
// read. Throughput is one item per cycle while the receiver takes results: the
// steering state is updated in the same cycle as the result is formed, so
// each item sees the state left by the one before it.
// A stalled receiver holds the result in the output register; the input
// register still takes one more item, after which tready falls until the
// output register drains.
// Reset (synchronous, active low) empties both registers, returns the steering
// to straight with no candidate, and loads the default register values.
module approach_steering_qualifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // front_left[9:0], front_right[19:10], left[29:20], right[39:30], now_ms[71:40]
    input  logic [71:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // push_correction[18:0], left_speed[26:19], right_speed[34:27],
    // steering_now[36:35], zero fill[39:37]
    output logic [39:0] o_m_axis_tdata,
    // push_mode[0]
    output logic        o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    asq_pkg::t_cfg         cfg;
    asq_pkg::t_in_item     r_s1_item;
    logic                  r_s1_valid;
    asq_pkg::t_result      r_out;
    logic                  r_out_valid;
    asq_pkg::t_steer_state r_state;
    asq_pkg::t_steer_state n_state;
    asq_pkg::t_result      n_out;
    logic                  s1_advance;
    logic                  in_accept;

    assign o_cfg_ready = 1'b1;

    asq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    asq_core u_core (
        .i_item       (r_s1_item),
        .i_cfg        (cfg),
        .i_state      (r_state),
        .o_next_state (n_state),
        .o_result     (n_out)
    );

    assign s1_advance      = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= asq_pkg::STATE_RESET;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= asq_pkg::t_in_item'(i_s_axis_tdata);
        end
        if (s1_advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.push_mode;
    assign o_m_axis_tdata  = {3'b000, r_out.steering_now, r_out.right_speed,
                              r_out.left_speed, r_out.push_correction};

endmodule

/* rtl/asq_cfg.sv */
module asq_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [asq_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  logic [asq_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output asq_pkg::t_cfg                    o_cfg
);

    asq_pkg::t_cfg r_cfg;
    asq_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                asq_pkg::CFG_DISTANCE_THRESHOLD:
                    n_cfg.distance_threshold = i_wr_data[asq_pkg::READING_W-1:0];
                asq_pkg::CFG_TURN_MARGIN:
                    n_cfg.turn_margin = i_wr_data[asq_pkg::READING_W-1:0];
                asq_pkg::CFG_TURN_HYSTERESIS:
                    n_cfg.turn_hysteresis = i_wr_data[asq_pkg::READING_W-1:0];
                asq_pkg::CFG_CONFIRM_TIME:
                    n_cfg.confirm_time = i_wr_data[asq_pkg::CONFIRM_W-1:0];
                asq_pkg::CFG_PUSH_GAIN:
                    n_cfg.push_gain = i_wr_data[asq_pkg::GAIN_W-1:0];
                asq_pkg::CFG_CRUISE_SPEED:
                    n_cfg.cruise_speed = i_wr_data[asq_pkg::SPEED_W-1:0];
                asq_pkg::CFG_INNER_SPEED:
                    n_cfg.inner_speed = i_wr_data[asq_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance_threshold <= asq_pkg::RST_DISTANCE_THRESHOLD;
            r_cfg.turn_margin        <= asq_pkg::RST_TURN_MARGIN;
            r_cfg.turn_hysteresis    <= asq_pkg::RST_TURN_HYSTERESIS;
            r_cfg.confirm_time       <= asq_pkg::RST_CONFIRM_TIME;
            r_cfg.push_gain          <= asq_pkg::RST_PUSH_GAIN;
            r_cfg.cruise_speed       <= asq_pkg::RST_CRUISE_SPEED;
            r_cfg.inner_speed        <= asq_pkg::RST_INNER_SPEED;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/asq_core.sv */
module asq_core (
    input  asq_pkg::t_in_item      i_item,
    input  asq_pkg::t_cfg          i_cfg,
    input  asq_pkg::t_steer_state  i_state,
    output asq_pkg::t_steer_state  o_next_state,
    output asq_pkg::t_result       o_result
);

    logic [asq_pkg::READING_W-1:0] front;
    logic [asq_pkg::READING_W-1:0] side;
    logic                          push;
    logic signed [11:0]            delta;
    logic signed [11:0]            margin;
    logic signed [11:0]            release_margin;
    logic signed [19:0]            product;
    logic [asq_pkg::TIME_W-1:0]    elapsed;
    logic                          confirmed;
    asq_pkg::t_steer               req;
    asq_pkg::t_steer_state         st;

    always_comb begin
        front = (i_item.front_left_reading > i_item.front_right_reading) ?
                i_item.front_left_reading : i_item.front_right_reading;
        side  = (i_item.left_reading > i_item.right_reading) ?
                i_item.left_reading : i_item.right_reading;
        push  = (front >= i_cfg.distance_threshold) && (front >= side);

        delta = $signed({2'b00, i_item.right_reading}) - $signed({2'b00, i_item.left_reading});
        margin = $signed({2'b00, i_cfg.turn_margin});
        release_margin = margin - $signed({2'b00, i_cfg.turn_hysteresis});
        product = delta * $signed({1'b0, i_cfg.push_gain});

        elapsed   = i_item.now_ms - i_state.candidate_start_time;
        confirmed = elapsed >= {{(asq_pkg::TIME_W-asq_pkg::CONFIRM_W){1'b0}},
                                i_cfg.confirm_time};
    end

    always_comb begin
        req = asq_pkg::DIR_STRAIGHT;
        if (delta > margin) begin
            req = asq_pkg::DIR_RIGHT;
        end else if (delta < -margin) begin
            req = asq_pkg::DIR_LEFT;
        end
        // An active turn is held down to the release margin and overrides a new request.
        if (i_state.active_steering == asq_pkg::DIR_RIGHT && delta > release_margin) begin
            req = asq_pkg::DIR_RIGHT;
        end else if (i_state.active_steering == asq_pkg::DIR_LEFT &&
                     delta < -release_margin) begin
            req = asq_pkg::DIR_LEFT;
        end
    end

    always_comb begin
        st = i_state;
        if (push) begin
            st = asq_pkg::STATE_RESET;
        end else if (req != i_state.active_steering) begin
            if (i_state.candidate_valid && req == i_state.candidate_steering) begin
                if (confirmed) begin
                    st = asq_pkg::STATE_RESET;
                    st.active_steering = req;
                end
            end else begin
                st.candidate_steering   = req;
                st.candidate_start_time = i_item.now_ms;
                st.candidate_valid      = 1'b1;
            end
        end else begin
            st = asq_pkg::STATE_RESET;
            st.active_steering = i_state.active_steering;
        end
        o_next_state = st;
    end

    always_comb begin
        o_result.push_mode       = push;
        o_result.steering_now    = st.active_steering;
        o_result.push_correction = '0;
        o_result.left_speed      = i_cfg.cruise_speed;
        o_result.right_speed     = i_cfg.cruise_speed;
        if (push) begin
            o_result.push_correction = product[asq_pkg::CORR_W-1:0];
            o_result.left_speed      = '0;
            o_result.right_speed     = '0;
        end else if (st.active_steering == asq_pkg::DIR_RIGHT) begin
            o_result.right_speed = i_cfg.inner_speed;
        end else if (st.active_steering == asq_pkg::DIR_LEFT) begin
            o_result.left_speed = i_cfg.inner_speed;
        end
    end

endmodule

/* rtl/asq_checker.sv */
module asq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // In push mode both speeds and the steering are zero.
    a_push_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[36:19] == 18'd0))
        else $error("push result with non-zero speed or steering");

    // In drive mode the correction is zero.
    a_drive_corr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[18:0] == 19'd0))
        else $error("drive result with non-zero correction");

    // Driving straight, both wheels run at the same speed.
    a_straight_speeds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser && o_m_axis_tdata[36:35] == 2'd0)
        |-> (o_m_axis_tdata[26:19] == o_m_axis_tdata[34:27]))
        else $error("straight drive with unequal wheel speeds");

    // A stalled result item holds.
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result item changed while stalled");

endmodule

bind approach_steering_qualifier asq_checker u_asq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

/* tb/steering_result_checker.sv */
module steering_result_checker
    import asq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  logic        i_item_ready,
    // Fields as in t_in_item, front_left_reading in the lowest bits.
    input  logic [71:0] i_item_data,
    input  logic        i_result_valid,
    input  logic        i_result_ready,
    // push_correction[18:0], left_speed[26:19], right_speed[34:27], steering_now[36:35]
    input  logic [39:0] i_result_data,
    // push_mode[0]
    input  logic        i_result_user,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int unsigned o_fail_count,
    output int unsigned o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg         regs;
    t_steer_state steer;
    t_result      expected_results[$];
    int unsigned  result_count;

    function automatic string result_text(input t_result r);
        return $sformatf("push=%0b corr=%0d left=%0d right=%0d steer=%0d",
                         r.push_mode, r.push_correction, r.left_speed, r.right_speed,
                         r.steering_now);
    endfunction

    // Works out the result of one sample set and advances the steering state.
    function automatic t_result predict_steering(input t_in_item it);
        int      front;
        int      side;
        int      delta;
        int      margin;
        int      release_lvl;
        t_steer  req;
        logic [TIME_W-1:0] elapsed;
        t_result res;
        front = int'((it.front_left_reading > it.front_right_reading) ?
                     it.front_left_reading : it.front_right_reading);
        side  = int'((it.left_reading > it.right_reading) ?
                     it.left_reading : it.right_reading);
        delta = int'(it.right_reading) - int'(it.left_reading);
        res   = '0;
        if (front >= int'(regs.distance_threshold) && front >= side) begin
            res.push_mode       = 1'b1;
            res.push_correction = CORR_W'(delta * int'(regs.push_gain));
            steer               = STATE_RESET;
            return res;
        end
        margin      = int'(regs.turn_margin);
        // May go negative when the hysteresis exceeds the margin.
        release_lvl = margin - int'(regs.turn_hysteresis);
        req = DIR_STRAIGHT;
        if (delta > margin)
            req = DIR_RIGHT;
        else if (delta < -margin)
            req = DIR_LEFT;
        if (steer.active_steering == DIR_RIGHT && delta > release_lvl)
            req = DIR_RIGHT;
        else if (steer.active_steering == DIR_LEFT && delta < -release_lvl)
            req = DIR_LEFT;
        if (req != steer.active_steering) begin
            if (steer.candidate_valid && req == steer.candidate_steering) begin
                elapsed = it.now_ms - steer.candidate_start_time;
                if (elapsed >= TIME_W'(regs.confirm_time)) begin
                    steer                 = STATE_RESET;
                    steer.active_steering = req;
                end
            end else begin
                steer.candidate_steering   = req;
                steer.candidate_start_time = it.now_ms;
                steer.candidate_valid      = 1'b1;
            end
        end else begin
            steer.candidate_steering   = DIR_STRAIGHT;
            steer.candidate_start_time = '0;
            steer.candidate_valid      = 1'b0;
        end
        res.left_speed  = regs.cruise_speed;
        res.right_speed = regs.cruise_speed;
        if (steer.active_steering == DIR_RIGHT)
            res.right_speed = regs.inner_speed;
        else if (steer.active_steering == DIR_LEFT)
            res.left_speed = regs.inner_speed;
        res.steering_now = steer.active_steering;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_in_item item;
        t_result  want;
        t_result  actual;
        if (!i_rst_n) begin
            regs = '{
                distance_threshold: RST_DISTANCE_THRESHOLD,
                turn_margin:        RST_TURN_MARGIN,
                turn_hysteresis:    RST_TURN_HYSTERESIS,
                confirm_time:       RST_CONFIRM_TIME,
                push_gain:          RST_PUSH_GAIN,
                cruise_speed:       RST_CRUISE_SPEED,
                inner_speed:        RST_INNER_SPEED
            };
            steer = STATE_RESET;
            expected_results.delete();
            result_count  = 0;
            o_fail_count  = 0;
            o_outstanding <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DISTANCE_THRESHOLD: regs.distance_threshold = i_cfg_data[READING_W-1:0];
                    CFG_TURN_MARGIN:        regs.turn_margin        = i_cfg_data[READING_W-1:0];
                    CFG_TURN_HYSTERESIS:    regs.turn_hysteresis    = i_cfg_data[READING_W-1:0];
                    CFG_CONFIRM_TIME:       regs.confirm_time       = i_cfg_data[CONFIRM_W-1:0];
                    CFG_PUSH_GAIN:          regs.push_gain          = i_cfg_data[GAIN_W-1:0];
                    CFG_CRUISE_SPEED:       regs.cruise_speed       = i_cfg_data[SPEED_W-1:0];
                    CFG_INNER_SPEED:        regs.inner_speed        = i_cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end
            if (i_item_valid && i_item_ready) begin
                item = i_item_data;
                expected_results.push_back(predict_steering(item));
            end
            if (i_result_valid && i_result_ready) begin
                actual.push_mode       = i_result_user;
                actual.push_correction = i_result_data[18:0];
                actual.left_speed      = i_result_data[26:19];
                actual.right_speed     = i_result_data[34:27];
                actual.steering_now    = t_steer'(i_result_data[36:35]);
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("result %0d arrived with none expected: got %s",
                                 result_count, result_text(actual));
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (actual !== want) begin
                        if (o_fail_count < 10)
                            $display("result %0d mismatch: expected %s, got %s",
                                     result_count, result_text(want), result_text(actual));
                        o_fail_count++;
                    end
                end
                result_count++;
            end
            o_outstanding <= expected_results.size();
        end
    end

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import asq_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned NUM_REGS     = 7;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_DISTANCE_THRESHOLD;
    logic [15:0] cfg_data  = '0;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycle_count = 0;
    int unsigned rx_hold     = 0;
    bit          quiet       = 1'b0;
    logic [31:0] clock_ms    = '0;
    t_cfg        live_cfg    = '{
        distance_threshold: RST_DISTANCE_THRESHOLD,
        turn_margin:        RST_TURN_MARGIN,
        turn_hysteresis:    RST_TURN_HYSTERESIS,
        confirm_time:       RST_CONFIRM_TIME,
        push_gain:          RST_PUSH_GAIN,
        cruise_speed:       RST_CRUISE_SPEED,
        inner_speed:        RST_INNER_SPEED
    };

    approach_steering_qualifier u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    steering_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (s_tvalid),
        .i_item_ready   (s_tready),
        .i_item_data    (s_tdata),
        .i_result_valid (m_tvalid),
        .i_result_ready (m_tready),
        .i_result_data  (m_tdata),
        .i_result_user  (m_tuser),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL approach_steering_qualifier");
            $finish;
        end
    end

    // Mostly no gap, some short ones and the odd long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            rx_hold  <= pick_gap();
        end
    end

    function automatic t_in_item make_item(input int fl, input int fr, input int lt,
                                           input int rt, input logic [31:0] now);
        t_in_item it;
        it.front_left_reading  = READING_W'(fl);
        it.front_right_reading = READING_W'(fr);
        it.left_reading        = READING_W'(lt);
        it.right_reading       = READING_W'(rt);
        it.now_ms              = now;
        return it;
    endfunction

    // Side readings with the given difference, front readings placed either at
    // or above both the threshold and the stronger side, or below one of them.
    function automatic t_in_item shaped_sample(input bit push, input int delta);
        int d;
        int lt;
        int rt;
        int floor_lvl;
        int front;
        int other;
        d = (delta > 1023) ? 1023 : (delta < -1023) ? -1023 : delta;
        if (d >= 0) begin
            lt = $urandom_range(0, 1023 - d);
            rt = lt + d;
        end else begin
            rt = $urandom_range(0, 1023 + d);
            lt = rt - d;
        end
        floor_lvl = (lt > rt) ? lt : rt;
        if (int'(live_cfg.distance_threshold) > floor_lvl)
            floor_lvl = int'(live_cfg.distance_threshold);
        if (push)
            front = $urandom_range(floor_lvl, 1023);
        else if (floor_lvl > 0)
            front = $urandom_range(0, floor_lvl - 1);
        else
            front = 0;
        other = $urandom_range(0, front);
        if ($urandom_range(0, 1) == 1)
            return make_item(front, other, lt, rt, clock_ms);
        return make_item(other, front, lt, rt, clock_ms);
    endfunction

    // Side differences on and around the turn and release margins, well beyond them, zero, or random.
    function automatic int pick_delta();
        int m;
        int rl;
        m  = int'(live_cfg.turn_margin);
        rl = m - int'(live_cfg.turn_hysteresis);
        case ($urandom_range(0, 11))
            0:  return m + 1;
            1:  return m;
            2:  return -m - 1;
            3:  return -m;
            4:  return rl + 1;
            5:  return rl;
            6:  return -rl - 1;
            7:  return -rl;
            8:  return 0;
            9:  return m + int'($urandom_range(2, 200));
            10: return -m - int'($urandom_range(2, 200));
            default: return int'($urandom_range(0, 2046)) - 1023;
        endcase
    endfunction

    function automatic logic [31:0] time_step();
        int unsigned r;
        int half;
        r    = $urandom_range(0, 99);
        half = int'(live_cfg.confirm_time) / 2;
        if (r < 45)
            return $urandom_range(0, 12);
        if (r < 75)
            return half + int'($urandom_range(0, 3));
        if (r < 93)
            return (live_cfg.confirm_time == 0) ? 0 :
                   int'(live_cfg.confirm_time) - 1 + int'($urandom_range(0, 2));
        return $urandom();
    endfunction

    function automatic int unsigned pick_level(input int unsigned top_lvl,
                                               input int unsigned lo, input int unsigned hi);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return top_lvl;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic configure(input t_cfg next);
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        for (int r = 0; r < NUM_REGS; r++) begin
            idx = CFG_IDX_W'(r);
            case (idx)
                CFG_DISTANCE_THRESHOLD: value = CFG_DATA_W'(next.distance_threshold);
                CFG_TURN_MARGIN:        value = CFG_DATA_W'(next.turn_margin);
                CFG_TURN_HYSTERESIS:    value = CFG_DATA_W'(next.turn_hysteresis);
                CFG_CONFIRM_TIME:       value = CFG_DATA_W'(next.confirm_time);
                CFG_PUSH_GAIN:          value = CFG_DATA_W'(next.push_gain);
                CFG_CRUISE_SPEED:       value = CFG_DATA_W'(next.cruise_speed);
                default:                value = CFG_DATA_W'(next.inner_speed);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            do @(posedge i_clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        live_cfg = next;
    endtask

    initial begin
        t_cfg         next;
        t_in_item     it;
        logic [95:0]  raw;
        int unsigned  sent;
        int unsigned  len;
        int           d;
        int           jitter;
        bit           push_seq;
        bit           noise;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: threshold 300, margin 100, hysteresis 30, confirm 50 ms.
        send_item(make_item(0, 0, 0, 0, 32'd0));
        send_item(make_item(1023, 0, 0, 1023, 32'd1));
        send_item(make_item(0, 1023, 1023, 0, 32'd2));
        // Front above threshold but weaker than the side: left request.
        send_item(make_item(500, 0, 600, 0, 32'd100));
        send_item(make_item(0, 0, 600, 0, 32'd149));
        send_item(make_item(0, 0, 600, 0, 32'd150));
        // Inside the release margin the left turn is held, beyond it released.
        send_item(make_item(0, 0, 80, 0, 32'd160));
        send_item(make_item(0, 0, 60, 0, 32'd170));
        send_item(make_item(0, 0, 60, 0, 32'd220));
        send_item(make_item(0, 0, 0, 101, 32'd300));
        send_item(make_item(0, 0, 0, 100, 32'd310));
        // Right request confirmed across the timestamp wrap.
        send_item(make_item(0, 0, 0, 101, 32'hFFFF_FFF0));
        send_item(make_item(0, 0, 0, 101, 32'h0000_0022));
        send_item(make_item(0, 0, 1023, 0, 32'h0000_0030));
        send_item(make_item(0, 0, 0, 500, 32'h0000_0040));
        // A new request replaces a pending one and restarts its time.
        send_item(make_item(0, 0, 0, 0, 32'h0000_0050));
        send_item(make_item(0, 0, 1023, 0, 32'h0000_0060));
        send_item(make_item(0, 0, 1023, 0, 32'h0000_0092));
        send_item(make_item(300, 0, 0, 0, 32'hFFFF_FFFF));

        // Hysteresis well above the margin, zero confirm time, full gain.
        wait_idle();
        next = '{
            distance_threshold: '0,
            turn_margin:        10'd10,
            turn_hysteresis:    10'd1023,
            confirm_time:       '0,
            push_gain:          8'd255,
            cruise_speed:       8'd255,
            inner_speed:        '0
        };
        configure(next);
        send_item(make_item(0, 0, 0, 0, 32'h0000_1000));
        send_item(make_item(0, 0, 0, 1023, 32'h0000_1001));
        send_item(make_item(0, 0, 0, 1023, 32'h0000_1001));
        send_item(make_item(0, 0, 500, 0, 32'h0000_1002));
        send_item(make_item(0, 0, 1023, 0, 32'h0000_1003));
        send_item(make_item(1023, 0, 1023, 0, 32'h0000_1004));
        send_item(make_item(0, 1023, 0, 1023, 32'h0000_1005));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            next = live_cfg;
            next.distance_threshold = READING_W'(pick_level(1023, 100, 900));
            next.turn_margin        = READING_W'(pick_level(1023, 0, 300));
            next.turn_hysteresis    = READING_W'(pick_level(1023, 0,
                                          (next.turn_margin > 973) ? 1023 :
                                          next.turn_margin + 50));
            next.confirm_time       = CONFIRM_W'(pick_level(65535, 0, 80));
            next.push_gain          = GAIN_W'(pick_level(255, 0, 255));
            next.cruise_speed       = SPEED_W'(pick_level(255, 0, 255));
            next.inner_speed        = SPEED_W'(pick_level(255, 0, 255));
            configure(next);
            clock_ms = $urandom();
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                // A run of samples that keeps one side difference, so that
                // requests live long enough to be confirmed.
                len      = $urandom_range(3, 12);
                push_seq = ($urandom_range(0, 3) == 0);
                d        = pick_delta();
                quiet    = ($urandom_range(0, 5) == 0);
                for (int k = 0; k < len; k++) begin
                    noise = ($urandom_range(0, 9) == 0);
                    if (noise) begin
                        raw = {$urandom(), $urandom(), $urandom()};
                        it  = raw[71:0];
                    end else begin
                        clock_ms = clock_ms + time_step();
                        jitter = ($urandom_range(0, 3) == 0) ?
                                 int'($urandom_range(0, 6)) - 3 : 0;
                        it = shaped_sample(push_seq ^ ($urandom_range(0, 9) == 0),
                                           d + jitter);
                    end
                    send_item(it);
                    sent++;
                end
            end
        end
        quiet = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS approach_steering_qualifier");
        end else begin
            $display("FAIL approach_steering_qualifier");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/asq_pkg.sv
rtl/asq_cfg.sv
rtl/asq_core.sv
rtl/approach_steering_qualifier.sv
rtl/asq_checker.sv
tb/steering_result_checker.sv
tb/tb.sv
